FILE: rtl/cgbi_pkg.sv
// Package for the Cartesian grid bin index block: payload types, register map and widths.
// Used by cgbi_axis and cartesian_grid_bin_index; depends on nothing else.
`timescale 1ns / 1ps

package cgbi_pkg;

    // Fixed-point and count widths.
    localparam int COORD_W = 32;   // Q16.16 signed coordinate
    localparam int WIDTH_W = 31;   // Q15.16 unsigned extent
    localparam int CNT_W   = 8;    // cells per axis
    localparam int IDX_W   = 24;   // linear cell index

    // Tolerance for all fuzzy compares, in Q16.16 LSBs, and the per-axis count ceiling.
    localparam int FUZZ_LSB       = 1;
    localparam int MAX_CELLS_AXIS = 255;

    // Difference of point and corner, with headroom for the fuzzed compares.
    localparam int DIFF_W = COORD_W + 3;
    // Dividend of the bin search: offset times count.
    localparam int NUM_W  = WIDTH_W + CNT_W;
    // One quotient bit per divider stage.
    localparam int DIV_STAGES = CNT_W;
    // Registers inside one axis lane: difference, product, then the divider stages.
    localparam int LANE_DEPTH = DIV_STAGES + 2;

    // APB register map.
    localparam int ADDR_W = 5;
    localparam int DATA_W = 32;
    localparam int REG_SEL_W = 3;

    localparam logic [REG_SEL_W-1:0] REG_CORNER_X   = 3'd0;
    localparam logic [REG_SEL_W-1:0] REG_CORNER_Y   = 3'd1;
    localparam logic [REG_SEL_W-1:0] REG_CORNER_Z   = 3'd2;
    localparam logic [REG_SEL_W-1:0] REG_WIDTH_X    = 3'd3;
    localparam logic [REG_SEL_W-1:0] REG_WIDTH_Y    = 3'd4;
    localparam logic [REG_SEL_W-1:0] REG_WIDTH_Z    = 3'd5;
    localparam logic [REG_SEL_W-1:0] REG_CELL_COUNT = 3'd6;
    localparam logic [REG_SEL_W-1:0] REG_CLAMP      = 3'd7;

    localparam logic [3*CNT_W-1:0] CELL_COUNT_RESET = 24'h010101;

    // Input word: one query point.
    typedef struct packed {
        logic signed [COORD_W-1:0] point_x;
        logic signed [COORD_W-1:0] point_y;
        logic signed [COORD_W-1:0] point_z;
    } point_t;

    // Output word: cell index and outside flag.
    typedef struct packed {
        logic [IDX_W-1:0] cell_index;
        logic             outside;
    } bin_t;

    // Grid settings for one axis.
    typedef struct packed {
        logic signed [COORD_W-1:0] corner;
        logic [WIDTH_W-1:0]        width;
        logic [CNT_W-1:0]          count;
    } axis_cfg_t;

    // What one axis lane hands on.
    typedef struct packed {
        logic [CNT_W-1:0] cell_no;
        logic             outside;
    } axis_res_t;

    // A count field of zero means one cell; larger counts saturate at the ceiling.
    function automatic logic [CNT_W-1:0] eff_count(input logic [CNT_W-1:0] raw);
        logic [CNT_W-1:0] n;
        n = raw;
        if (n == '0) begin
            n = CNT_W'(1);
        end
        if (32'(n) > MAX_CELLS_AXIS) begin
            n = CNT_W'(MAX_CELLS_AXIS);
        end
        return n;
    endfunction

endpackage

FILE: rtl/cgbi_axis.sv
// One axis lane: finds the cell of a coordinate with a bit-per-stage restoring divider.
// Depends on cgbi_pkg.
`timescale 1ns / 1ps

module cgbi_axis (
    input  logic                              aclk,
    input  logic                              en,
    input  logic signed [cgbi_pkg::COORD_W-1:0] coord,
    input  cgbi_pkg::axis_cfg_t               cfg,
    output cgbi_pkg::axis_res_t               res
);
    import cgbi_pkg::*;

    localparam logic signed [DIFF_W-1:0] FUZZ_S = DIFF_W'(FUZZ_LSB);
    localparam logic signed [DIFF_W-1:0] ZERO_S = DIFF_W'(0);

    logic signed [DIFF_W-1:0] diff;
    logic signed [DIFF_W-1:0] width_s;
    logic signed [DIFF_W-1:0] diff_reg;
    logic                     out_reg;
    logic                     top_reg;
    logic                     low_reg;

    logic [NUM_W-1:0]         prod;
    logic [NUM_W-1:0]         rem_reg  [0:DIV_STAGES];
    logic [CNT_W-1:0]         quo_reg  [0:DIV_STAGES];
    logic                     out_pipe [0:DIV_STAGES];
    logic                     top_pipe [0:DIV_STAGES];
    logic                     low_pipe [0:DIV_STAGES];

    // Offset from the corner and the three range tests against the extent and the corner.
    assign width_s = $signed(DIFF_W'(cfg.width));
    assign diff    = DIFF_W'(coord) - DIFF_W'(cfg.corner);

    always_ff @(posedge aclk) begin
        if (en) begin
            diff_reg <= diff;
            out_reg  <= (diff < -FUZZ_S) || (diff > width_s + FUZZ_S);
            top_reg  <= (diff >= width_s - FUZZ_S);
            low_reg  <= (diff <= ZERO_S);
        end
    end

    // The first border at or above the offset d is j = ceil(d*n/w), so the cell is
    // floor((d*n - 1) / w). Only used when 0 < d < w, so d fits the width field.
    assign prod = NUM_W'(diff_reg[WIDTH_W-1:0]) * NUM_W'(cfg.count);

    always_ff @(posedge aclk) begin
        if (en) begin
            rem_reg[0]  <= prod - NUM_W'(1);
            quo_reg[0]  <= '0;
            out_pipe[0] <= out_reg;
            top_pipe[0] <= top_reg;
            low_pipe[0] <= low_reg;
        end
    end

    // Restoring division, most significant quotient bit first, one bit per stage.
    for (genvar s = 0; s < DIV_STAGES; s++) begin : g_div
        localparam int BIT = DIV_STAGES - 1 - s;
        logic [NUM_W-1:0] divisor;
        logic             fits;

        assign divisor = NUM_W'(cfg.width) << BIT;
        assign fits    = (rem_reg[s] >= divisor);

        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[s+1]  <= fits ? (rem_reg[s] - divisor) : rem_reg[s];
                quo_reg[s+1]  <= quo_reg[s] | (CNT_W'(fits) << BIT);
                out_pipe[s+1] <= out_pipe[s];
                top_pipe[s+1] <= top_pipe[s];
                low_pipe[s+1] <= low_pipe[s];
            end
        end
    end

    // At or past the top goes to the last cell; at or below the corner to the first.
    always_comb begin
        res.outside = out_pipe[DIV_STAGES];
        if (top_pipe[DIV_STAGES]) begin
            res.cell_no = cfg.count - CNT_W'(1);
        end else if (low_pipe[DIV_STAGES]) begin
            res.cell_no = '0;
        end else begin
            res.cell_no = quo_reg[DIV_STAGES];
        end
    end

endmodule

FILE: rtl/cartesian_grid_bin_index.sv
// Top level of the Cartesian grid bin index block: APB registers, three axis lanes,
// index assembly and the output register. Depends on cgbi_pkg and cgbi_axis.
//
//   Channel   Ports                       Word / width
//   --------  --------------------------  ------------------------------------
//   input     s_valid, s_ready, s_data    point_t: point_x/y/z, 3 x 32 bit
//   output    m_valid, m_ready, m_data    bin_t: cell_index 24 bit, outside
//   config    psel .. pready, APB         32-bit registers at 4*i, 8 registers
//
// m_valid rises once an accepted word has passed twelve register stages, the first loaded at
// the edge that accepts it: ten in the axis lanes, set by the eight-stage divider that finds
// the cell, one for the index products, one output.
// One word enters per cycle while the output is free or being taken.
// m_ready low while m_valid is high freezes the whole pipeline, so s_ready falls with it and nothing is lost.
// Reset (aresetn low, synchronous) clears the valid bits and loads the register defaults.
`timescale 1ns / 1ps

module cartesian_grid_bin_index (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  cgbi_pkg::point_t              s_data,
    output logic                          m_valid,
    input  logic                          m_ready,
    output cgbi_pkg::bin_t                m_data,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [cgbi_pkg::ADDR_W-1:0]   paddr,
    input  logic [cgbi_pkg::DATA_W-1:0]   pwdata,
    output logic [cgbi_pkg::DATA_W-1:0]   prdata,
    output logic                          pready
);
    import cgbi_pkg::*;

    localparam int PIPE_DEPTH = LANE_DEPTH + 1;

    logic signed [COORD_W-1:0] corner_x_reg, corner_y_reg, corner_z_reg;
    logic [WIDTH_W-1:0]        width_x_reg, width_y_reg, width_z_reg;
    logic [3*CNT_W-1:0]        cell_counts_reg;
    logic                      clamp_reg;
    logic [CNT_W-1:0]          nx_reg, ny_reg, nz_reg;
    logic [2*CNT_W-1:0]        nxny_reg;

    logic                      wr_en;
    logic [REG_SEL_W-1:0]      reg_sel;
    logic                      en;

    axis_cfg_t                 cfg_x, cfg_y, cfg_z;
    axis_res_t                 res_x, res_y, res_z;

    logic                      vld_reg [0:PIPE_DEPTH-1];
    logic [CNT_W-1:0]          ix_reg;
    logic [2*CNT_W-1:0]        row_reg;
    logic [IDX_W-1:0]          plane_reg;
    logic                      outside_reg;
    logic                      m_valid_reg;
    bin_t                      m_data_reg;
    logic [IDX_W-1:0]          index_sum;

    // Configuration port: writes land on the access phase, reads are combinational.
    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_sel = paddr[ADDR_W-1:2];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            corner_x_reg    <= '0;
            corner_y_reg    <= '0;
            corner_z_reg    <= '0;
            width_x_reg     <= '0;
            width_y_reg     <= '0;
            width_z_reg     <= '0;
            cell_counts_reg <= CELL_COUNT_RESET;
            clamp_reg       <= 1'b0;
        end else if (wr_en) begin
            unique case (reg_sel)
                REG_CORNER_X:   corner_x_reg    <= $signed(pwdata);
                REG_CORNER_Y:   corner_y_reg    <= $signed(pwdata);
                REG_CORNER_Z:   corner_z_reg    <= $signed(pwdata);
                REG_WIDTH_X:    width_x_reg     <= pwdata[WIDTH_W-1:0];
                REG_WIDTH_Y:    width_y_reg     <= pwdata[WIDTH_W-1:0];
                REG_WIDTH_Z:    width_z_reg     <= pwdata[WIDTH_W-1:0];
                REG_CELL_COUNT: cell_counts_reg <= pwdata[3*CNT_W-1:0];
                REG_CLAMP:      clamp_reg       <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_sel)
            REG_CORNER_X:   prdata = corner_x_reg;
            REG_CORNER_Y:   prdata = corner_y_reg;
            REG_CORNER_Z:   prdata = corner_z_reg;
            REG_WIDTH_X:    prdata = DATA_W'(width_x_reg);
            REG_WIDTH_Y:    prdata = DATA_W'(width_y_reg);
            REG_WIDTH_Z:    prdata = DATA_W'(width_z_reg);
            REG_CELL_COUNT: prdata = DATA_W'(cell_counts_reg);
            REG_CLAMP:      prdata = DATA_W'(clamp_reg);
            default:        prdata = '0;
        endcase
    end

    // Effective counts are registered from the count register, and the plane size from them.
    always_ff @(posedge aclk) begin
        nx_reg   <= eff_count(cell_counts_reg[CNT_W-1:0]);
        ny_reg   <= eff_count(cell_counts_reg[2*CNT_W-1:CNT_W]);
        nz_reg   <= eff_count(cell_counts_reg[3*CNT_W-1:2*CNT_W]);
        nxny_reg <= (2*CNT_W)'(nx_reg) * (2*CNT_W)'(ny_reg);
    end

    // The pipeline advances whenever the output register is free or being emptied.
    assign en      = !m_valid_reg || m_ready;
    assign s_ready = en;

    assign cfg_x = '{corner: corner_x_reg, width: width_x_reg, count: nx_reg};
    assign cfg_y = '{corner: corner_y_reg, width: width_y_reg, count: ny_reg};
    assign cfg_z = '{corner: corner_z_reg, width: width_z_reg, count: nz_reg};

    // One lane per axis.
    cgbi_axis u_axis_x (
        .aclk  (aclk),
        .en    (en),
        .coord (s_data.point_x),
        .cfg   (cfg_x),
        .res   (res_x)
    );

    cgbi_axis u_axis_y (
        .aclk  (aclk),
        .en    (en),
        .coord (s_data.point_y),
        .cfg   (cfg_y),
        .res   (res_y)
    );

    cgbi_axis u_axis_z (
        .aclk  (aclk),
        .en    (en),
        .coord (s_data.point_z),
        .cfg   (cfg_z),
        .res   (res_z)
    );

    // Valid bits run alongside the lane stages and the product stage.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < PIPE_DEPTH; i++) begin
                vld_reg[i] <= 1'b0;
            end
            m_valid_reg <= 1'b0;
        end else if (en) begin
            vld_reg[0] <= s_valid;
            for (int i = 1; i < PIPE_DEPTH; i++) begin
                vld_reg[i] <= vld_reg[i-1];
            end
            m_valid_reg <= vld_reg[PIPE_DEPTH-1];
        end
    end

    // Row and plane offsets of the Y and Z cells.
    always_ff @(posedge aclk) begin
        if (en) begin
            ix_reg      <= res_x.cell_no;
            row_reg     <= (2*CNT_W)'(nx_reg) * (2*CNT_W)'(res_y.cell_no);
            plane_reg   <= IDX_W'(nxny_reg) * IDX_W'(res_z.cell_no);
            outside_reg <= !clamp_reg && (res_x.outside || res_y.outside || res_z.outside);
        end
    end

    // Linear index with X running fastest; unless clamping is on, an outside point reports index zero.
    assign index_sum = IDX_W'(ix_reg) + IDX_W'(row_reg) + plane_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            m_data_reg.cell_index <= outside_reg ? '0 : index_sum;
            m_data_reg.outside    <= outside_reg;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule
